>>> hw/rtl/pss_pkg.sv
// Package: shared types, codes and field layout of the process scheduler select block.
`default_nettype none
package pss_pkg;

	// input item kinds (carried on tuser)
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_ENQ    = 2'd1;
	localparam logic [1:0] MODE_DECIDE = 2'd2;

	// scheduling policies
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_SJF  = 2'd2;
	localparam logic [1:0] POL_PSJF = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_POLICY  = 2'd0;
	localparam logic [1:0] CFG_PCOUNT  = 2'd1;
	localparam logic [1:0] CFG_QUANTUM = 2'd2;

	localparam logic [15:0] QUANTUM_RESET = 16'd500;

	// input tdata layout, lowest bit first
	localparam int IN_TDATA_W  = 144;
	localparam int OFS_SLOT    = 0;
	localparam int OFS_ARRIVE  = 5;
	localparam int OFS_WORK    = 37;
	localparam int OFS_HASARR  = 69;
	localparam int OFS_RUNVLD  = 70;
	localparam int OFS_RUNIDX  = 71;
	localparam int OFS_NOW     = 76;
	localparam int OFS_SSTART  = 108;
	localparam int OUT_TDATA_W = 8;

	// one process table row
	typedef struct packed {
		logic [31:0] ready_time;
		logic [31:0] remaining;
	} row_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOD_STEP,
		ST_MOD_END,
		ST_RR_POP,
		ST_RR_TAKE,
		ST_RR_SRCH,
		ST_RR_PUT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> hw/rtl/process_scheduler_select.sv
// Top level: process table, RR ring queue and a sequencer around one shared 32-bit subtractor.
// Write/enqueue give no result; a kept process needs no scan; a table scan reads n rows, one
// per cycle; RR runs 32 remainder steps for a running process, at a slice end pops and searches
// the Q entries left, and with none running only pops. One item in flight; the next is taken in
// the cycle after its result is loaded (held while full). Reset: arst_n clears control state,
// queue pointers and arrived flags and loads config defaults; tables need no clearing pass.
`default_nettype none
module process_scheduler_select #(
	parameter int MAX_PROCS   = 32,
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// slot, arrive_time, work_left, has_arrived, running_valid, running_index,
	// now_time, slice_start, zero pad
	input  wire logic [pss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// mode
	input  wire logic [1:0]                        s_axis_tuser,
	// result stream
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// next_index, zero pad
	output logic [pss_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// next_valid
	output logic                                   m_axis_tuser,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [15:0]                       cfg_data
);
	import pss_pkg::*;

	localparam int PW   = $clog2(MAX_PROCS);
	localparam int CW   = $clog2(MAX_PROCS + 1);
	localparam int QPW  = $clog2(QUEUE_DEPTH);
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
	localparam int CNTW = (CW > QCW) ? CW : QCW;

	// input field views
	logic [4:0]  in_slot;
	logic [31:0] in_arrive, in_work, in_now, in_sstart;
	logic        in_hasarr, in_runvld;
	logic [4:0]  in_runidx;
	logic [1:0]  in_mode;
	logic        in_fire;

	assign in_slot   = s_axis_tdata[OFS_SLOT +: 5];
	assign in_arrive = s_axis_tdata[OFS_ARRIVE +: 32];
	assign in_work   = s_axis_tdata[OFS_WORK +: 32];
	assign in_hasarr = s_axis_tdata[OFS_HASARR];
	assign in_runvld = s_axis_tdata[OFS_RUNVLD];
	assign in_runidx = s_axis_tdata[OFS_RUNIDX +: 5];
	assign in_now    = s_axis_tdata[OFS_NOW +: 32];
	assign in_sstart = s_axis_tdata[OFS_SSTART +: 32];
	assign in_mode   = s_axis_tuser;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	// config registers; the port never stalls
	logic [1:0]  policy_q;
	logic [5:0]  pcount_q;
	logic [15:0] quantum_q;
	assign cfg_ready = 1'b1;

	// sequencer and datapath state
	state_t            state_q, state_d;
	logic [MAX_PROCS-1:0] arrived_q;
	logic [QPW-1:0]    head_q, tail_q, pos_q;
	logic [QCW-1:0]    qcount_q;
	logic [CNTW-1:0]   cnt_q;
	logic [CW-1:0]     n_q;
	logic              pend_s1;
	logic [PW-1:0]     idx_s1;
	logic              found_q;
	logic [31:0]       best_q;
	logic              sel_vld_q;
	logic [4:0]        sel_q;
	logic [4:0]        run_idx_q;
	logic              rr_req_q;
	logic [4:0]        k_q;
	logic              left_nz_q;
	logic              hit_q;
	logic [31:0]       div_q;
	logic [15:0]       rem_q;
	logic [4:0]        bit_q;
	logic              out_valid_q, out_nv_q;
	logic [4:0]        out_idx_q;

	// memories
	row_t       row_mem [MAX_PROCS];
	logic [4:0] q_mem   [QUEUE_DEPTH];
	row_t       row_rd_q;
	logic [4:0] q_rd_q;

	// control from the output decode
	logic          row_we, q_we;
	logic [PW-1:0] row_waddr, row_raddr;
	logic [QPW-1:0] q_waddr, q_raddr;
	logic [4:0]    q_wdata;
	logic [31:0]   op_a, op_b;
	logic [32:0]   unit_res;
	logic          unit_borrow;

	// shared subtract/compare unit
	assign unit_res    = {1'b0, op_a} - {1'b0, op_b};
	assign unit_borrow = unit_res[32];

	// derived terms
	logic        slot_ok, run_ok, q_full, q_empty;
	logic        scan_issue, srch_issue;
	logic        out_free;
	logic        elig;
	logic [31:0] scan_key;
	logic [16:0] rem_shift;
	logic        boundary_now;

	assign slot_ok    = int'(in_slot) < MAX_PROCS;
	assign run_ok     = int'(run_idx_q) < MAX_PROCS;
	assign q_full     = qcount_q == QCW'(QUEUE_DEPTH);
	assign q_empty    = qcount_q == '0;
	assign scan_issue = cnt_q < CNTW'(n_q);
	assign srch_issue = cnt_q < CNTW'(qcount_q);
	assign out_free   = !out_valid_q || m_axis_tready;
	assign elig       = arrived_q[idx_s1] && (row_rd_q.remaining != '0);
	assign scan_key   = (policy_q == POL_FIFO) ? row_rd_q.ready_time : row_rd_q.remaining;
	assign rem_shift  = {rem_q, div_q[31]};
	assign boundary_now = quantum_q == '0;

	function automatic logic [QPW-1:0] ring_next(input logic [QPW-1:0] p);
		ring_next = (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_mode == MODE_DECIDE) begin
					if (in_runvld && (policy_q == POL_FIFO || policy_q == POL_SJF))
						state_d = ST_DONE;
					else if (policy_q != POL_RR)
						state_d = ST_SCAN;
					else if (!in_runvld)
						state_d = q_empty ? ST_DONE : ST_RR_POP;
					else if (boundary_now)
						state_d = q_empty ? ST_DONE : ST_RR_POP;
					else
						state_d = ST_MOD_STEP;
				end
			end
			ST_SCAN: begin
				if (!scan_issue && !pend_s1)
					state_d = ST_DONE;
			end
			ST_MOD_STEP: begin
				if (bit_q == '0)
					state_d = ST_MOD_END;
			end
			ST_MOD_END: begin
				state_d = (rem_q == '0 && !q_empty) ? ST_RR_POP : ST_DONE;
			end
			ST_RR_POP:  state_d = ST_RR_TAKE;
			ST_RR_TAKE: state_d = rr_req_q ? ST_RR_SRCH : ST_DONE;
			ST_RR_SRCH: begin
				if (!srch_issue && !pend_s1)
					state_d = ST_RR_PUT;
			end
			ST_RR_PUT:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, memory ports, shared unit operands
	always_comb begin
		s_axis_tready = 1'b0;
		row_we    = 1'b0;
		row_waddr = PW'(in_slot);
		row_raddr = cnt_q[PW-1:0];
		q_we      = 1'b0;
		q_waddr   = tail_q;
		q_wdata   = in_slot;
		q_raddr   = pos_q;
		op_a      = in_now;
		op_b      = in_sstart;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				row_we = in_fire && in_mode == MODE_WRITE && slot_ok;
				q_we   = in_fire && in_mode == MODE_ENQ && slot_ok && !q_full;
			end
			ST_SCAN: begin
				op_a = scan_key;
				op_b = best_q;
			end
			ST_MOD_STEP: begin
				op_a = 32'(rem_shift);
				op_b = 32'(quantum_q);
			end
			ST_RR_POP: begin
				q_raddr   = head_q;
				row_raddr = PW'(run_idx_q);
			end
			ST_RR_PUT: begin
				q_wdata = run_idx_q;
				q_we    = left_nz_q && !hit_q && run_idx_q != k_q && !q_full;
			end
			default: begin
			end
		endcase
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[row_waddr] <= '{ready_time: in_arrive, remaining: in_work};
		row_rd_q <= row_mem[row_raddr];
		if (q_we)
			q_mem[q_waddr] <= q_wdata;
		q_rd_q <= q_mem[q_raddr];
	end

	// state, config, queue pointers, arrived flags, output register, read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_FIFO;
			pcount_q    <= '0;
			quantum_q   <= QUANTUM_RESET;
			arrived_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			qcount_q    <= '0;
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POLICY:  policy_q  <= cfg_data[1:0];
					CFG_PCOUNT:  pcount_q  <= cfg_data[5:0];
					CFG_QUANTUM: quantum_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (row_we)
				arrived_q[row_waddr] <= in_hasarr;
			if (q_we) begin
				tail_q   <= ring_next(tail_q);
				qcount_q <= qcount_q + 1'b1;
			end
			if (state_q == ST_RR_POP) begin
				head_q   <= ring_next(head_q);
				qcount_q <= qcount_q - 1'b1;
			end
			// result register
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// read pipeline flag for scan and queue search
			case (state_q)
				ST_SCAN:    pend_s1 <= scan_issue;
				ST_RR_SRCH: pend_s1 <= srch_issue;
				default:    pend_s1 <= 1'b0;
			endcase
		end
	end

	// payload datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				run_idx_q <= in_runidx;
				cnt_q     <= '0;
				found_q   <= 1'b0;
				sel_vld_q <= in_runvld;
				sel_q     <= in_runidx;
				rr_req_q  <= in_runvld;
				div_q     <= unit_res[31:0];
				rem_q     <= '0;
				bit_q     <= 5'd31;
				n_q       <= (int'(pcount_q) > MAX_PROCS) ? CW'(MAX_PROCS) : CW'(pcount_q);
			end
			ST_SCAN: begin
				if (scan_issue)
					cnt_q <= cnt_q + 1'b1;
				idx_s1 <= cnt_q[PW-1:0];
				if (pend_s1 && elig && (!found_q || unit_borrow)) begin
					found_q <= 1'b1;
					best_q  <= scan_key;
					sel_q   <= 5'(idx_s1);
				end
				sel_vld_q <= found_q || (pend_s1 && elig);
			end
			ST_MOD_STEP: begin
				// one restoring remainder step per cycle
				rem_q <= unit_borrow ? rem_shift[15:0] : unit_res[15:0];
				div_q <= {div_q[30:0], 1'b0};
				bit_q <= bit_q - 1'b1;
			end
			ST_RR_TAKE: begin
				k_q       <= q_rd_q;
				sel_q     <= q_rd_q;
				sel_vld_q <= 1'b1;
				left_nz_q <= run_ok && (row_rd_q.remaining != '0);
				hit_q     <= 1'b0;
				cnt_q     <= '0;
				pos_q     <= head_q;
			end
			ST_RR_SRCH: begin
				if (srch_issue) begin
					cnt_q <= cnt_q + 1'b1;
					pos_q <= ring_next(pos_q);
				end
				if (pend_s1 && q_rd_q == run_idx_q)
					hit_q <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_nv_q  <= sel_vld_q;
					out_idx_q <= sel_vld_q ? sel_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_nv_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 5){1'b0}}, out_idx_q};

endmodule
`default_nettype wire
